// File: src/serial_arm_forward_kinematics_defines.svh
// Assertion macros shared by the forward kinematics block.
`ifndef SERIAL_ARM_FORWARD_KINEMATICS_DEFINES_SVH
`define SERIAL_ARM_FORWARD_KINEMATICS_DEFINES_SVH
`ifndef SYNTHESIS
`define SAFK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: property failed");
`define SAFK_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition");
`else
`define SAFK_ASSERT(lbl, prop)
`define SAFK_NEVER(lbl, cond)
`endif
`endif

// File: src/safk_pkg.sv
`default_nettype none
package safk_pkg;

  localparam int NumSegments   = 6;
  localparam int NumJoints     = 6;
  localparam int AngleFracBits = 27;
  localparam int CordicSteps   = 28;

  localparam int SegEff = (NumSegments < NumJoints) ? NumSegments : NumJoints;
  localparam int StepW  = $clog2(CordicSteps);
  localparam int SegW   = $clog2(NumJoints);

  typedef logic signed [31:0] q32_t;
  typedef q32_t [0:8] mat_t;
  typedef q32_t [0:2] vec_t;

  typedef struct packed {
    mat_t r;
    vec_t p;
  } pose_t;

  typedef logic signed [34:0] trig_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sc_t;

  typedef sc_t [0:NumJoints-1] sc_vec_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic               neg;
  } cordic_t;

  typedef cordic_t [0:NumJoints-1] lanes_t;
  typedef q32_t [0:NumJoints-1] joints_t;

  localparam q32_t OneQ = 32'sd1073741824;

  localparam logic signed [63:0] PiQ60   = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] GainQ60 = 64'sd700114967507363215;
  localparam int ZShift = 60 - AngleFracBits;

  // pi and period in the angle format, offset that makes any input nonnegative
  localparam longint PiF    = (PiQ60 + (64'sd1 <<< (ZShift - 1))) >>> ZShift;
  localparam longint Period = 2 * PiF;
  localparam longint Wraps  = 64'sd2147483648 / Period + 1;
  localparam longint Offset = PiF + Wraps * Period;
  localparam longint MaxV   = 64'sd2147483648 + Offset;
  localparam int ModSteps   = $clog2(MaxV / Period + 1);
  localparam int VW         = $clog2(MaxV) + 2;
  localparam int RedW       = $clog2(PiF + 1) + 2;

  localparam pose_t PoseIdent = '{r: '{OneQ, 32'sd0, 32'sd0, 32'sd0, OneQ, 32'sd0,
                                        32'sd0, 32'sd0, OneQ},
                                   p: '{32'sd0, 32'sd0, 32'sd0}};

  localparam mat_t SegRot [0:NumJoints-1] = '{
    '{OneQ, 32'sd0, 32'sd0, 32'sd0, OneQ, 32'sd0, 32'sd0, 32'sd0, OneQ},
    '{32'sd6793, 32'sd0, OneQ, 32'sd0, OneQ, 32'sd0, -OneQ, 32'sd0, 32'sd6793},
    '{OneQ, 32'sd0, 32'sd0, 32'sd0, OneQ, 32'sd0, 32'sd0, 32'sd0, OneQ},
    '{32'sd7330, -32'sd2899, OneQ, 32'sd0, OneQ, 32'sd2899, -OneQ, 32'sd0, 32'sd7330},
    '{OneQ, 32'sd0, 32'sd0, 32'sd0, OneQ, 32'sd0, 32'sd0, 32'sd0, OneQ},
    '{OneQ, 32'sd0, 32'sd0, 32'sd0, OneQ, 32'sd0, 32'sd0, 32'sd0, OneQ}
  };

  localparam vec_t SegPos [0:NumJoints-1] = '{
    '{32'sd0, 32'sd0, 32'sd34171834},
    '{32'sd0, 32'sd59308398, 32'sd0},
    '{-32'sd1047, -32'sd46144055, 32'sd164282499},
    '{-32'sd966, 32'sd0, 32'sd153625611},
    '{32'sd81, 32'sd30843234, 32'sd81},
    '{32'sd0, -32'sd81, 32'sd31057982}
  };

  localparam vec_t SegAxis [0:NumJoints-1] = '{
    '{32'sd0, 32'sd0, OneQ}, '{32'sd0, OneQ, 32'sd0}, '{32'sd0, OneQ, 32'sd0},
    '{32'sd0, OneQ, 32'sd0}, '{32'sd0, 32'sd0, -OneQ}, '{32'sd0, OneQ, 32'sd0}
  };

  localparam mat_t ToolRot = '{
    -32'sd3231, -32'sd879557140, 32'sd615873966,
    -OneQ, 32'sd3961, 32'sd24,
    -32'sd2291, -32'sd615873966, -32'sd879557140
  };

  localparam vec_t ToolPos = '{-32'sd127176664, 32'sd43835511, -32'sd20698789};

  localparam vec_t ZeroPos = '{32'sd0, 32'sd0, 32'sd0};

  typedef logic signed [63:0] atan_tab_t [0:CordicSteps-1];

  // atan(2^-i) in Q.60 from its odd power series, long division bit by bit
  function automatic atan_tab_t build_atan();
    atan_tab_t tab;
    longint sum;
    longint term;
    longint rem;
    int e;
    int d;
    tab[0] = PiQ60 >>> 2;
    for (int i = 1; i < CordicSteps; i++) begin
      sum = 0;
      for (int k = 0; k < 31; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          d = 2 * k + 1;
          term = 0;
          rem = 0;
          for (int b = 60 - e; b >= 0; b--) begin
            rem = (rem <<< 1) | ((b == 60 - e) ? 64'sd1 : 64'sd0);
            if (rem >= longint'(d)) begin
              rem = rem - longint'(d);
              term = term | (64'sd1 <<< b);
            end
          end
          sum = (k % 2 == 1) ? sum - term : sum + term;
        end
      end
      tab[i] = sum;
    end
    return tab;
  endfunction

  localparam atan_tab_t AtanTab = build_atan();

  function automatic q32_t sat32(input logic signed [71:0] x);
    if (x > 72'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -72'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [33:0] rnd30(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = (x + 64'sd536870912) >>> 30;
    return t[33:0];
  endfunction

  // multiply by an axis component; unit and zero components fold to wiring
  function automatic q32_t qmul_ax(input logic signed [35:0] v, input q32_t a);
    logic signed [71:0] pr;
    pr = 72'(v) * 72'(a);
    if (a == OneQ) begin
      return sat32(72'(v));
    end else if (a == -OneQ) begin
      return sat32(-72'(v));
    end
    return sat32((pr + 72'sd536870912) >>> 30);
  endfunction

  function automatic mat_t rodrigues(input vec_t a, input trig_t s, input trig_t c);
    mat_t m;
    logic signed [35:0] t;
    q32_t txx, tyy, tzz, txy, txz, tyz, sx, sy, sz;
    t   = 36'(OneQ) - 36'(c);
    txx = qmul_ax(36'(qmul_ax(t, a[0])), a[0]);
    tyy = qmul_ax(36'(qmul_ax(t, a[1])), a[1]);
    tzz = qmul_ax(36'(qmul_ax(t, a[2])), a[2]);
    txy = qmul_ax(36'(qmul_ax(t, a[0])), a[1]);
    txz = qmul_ax(36'(qmul_ax(t, a[0])), a[2]);
    tyz = qmul_ax(36'(qmul_ax(t, a[1])), a[2]);
    sx  = qmul_ax(36'(s), a[0]);
    sy  = qmul_ax(36'(s), a[1]);
    sz  = qmul_ax(36'(s), a[2]);
    m[0] = sat32(72'(txx) + 72'(c));
    m[1] = sat32(72'(txy) + 72'(sz));
    m[2] = sat32(72'(txz) - 72'(sy));
    m[3] = sat32(72'(txy) - 72'(sz));
    m[4] = sat32(72'(tyy) + 72'(c));
    m[5] = sat32(72'(tyz) + 72'(sx));
    m[6] = sat32(72'(txz) + 72'(sy));
    m[7] = sat32(72'(tyz) - 72'(sx));
    m[8] = sat32(72'(tzz) + 72'(c));
    return m;
  endfunction

endpackage
`default_nettype wire

// File: src/safk_angle_prep.sv
`default_nettype none
module safk_angle_prep (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire safk_pkg::joints_t joints_i,
  output safk_pkg::lanes_t      lanes_o
);

  logic signed [safk_pkg::RedW-1:0] red_q [0:safk_pkg::NumJoints-1];
  logic signed [safk_pkg::RedW-1:0] red_d [0:safk_pkg::NumJoints-1];
  safk_pkg::lanes_t lanes_d, lanes_q;

  // modulo by the period as ModSteps compare/subtract digits
  always_comb begin
    logic signed [safk_pkg::VW-1:0] v;
    for (int l = 0; l < safk_pkg::NumJoints; l++) begin
      v = safk_pkg::VW'(joints_i[l]) + safk_pkg::VW'(safk_pkg::Offset);
      for (int b = safk_pkg::ModSteps - 1; b >= 0; b--) begin
        if (v >= safk_pkg::VW'(safk_pkg::Period <<< b)) begin
          v = v - safk_pkg::VW'(safk_pkg::Period <<< b);
        end
      end
      v = v - safk_pkg::VW'(safk_pkg::PiF);
      red_d[l] = v[safk_pkg::RedW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q <= red_d;
    end
  end

  // fold into [-pi/2, pi/2]; the sign flip is applied after the rotations
  always_comb begin
    logic signed [63:0] z;
    for (int l = 0; l < safk_pkg::NumJoints; l++) begin
      z = 64'(red_q[l]) <<< safk_pkg::ZShift;
      lanes_d[l].neg = 1'b0;
      if (z > (safk_pkg::PiQ60 >>> 1)) begin
        z = z - safk_pkg::PiQ60;
        lanes_d[l].neg = 1'b1;
      end else if (z < -(safk_pkg::PiQ60 >>> 1)) begin
        z = z + safk_pkg::PiQ60;
        lanes_d[l].neg = 1'b1;
      end
      lanes_d[l].z = z;
      lanes_d[l].x = safk_pkg::GainQ60;
      lanes_d[l].y = 64'sd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign lanes_o = lanes_q;

endmodule
`default_nettype wire

// File: src/safk_cordic_cell.sv
`default_nettype none
module safk_cordic_cell (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [safk_pkg::StepW-1:0] step_i,
  input  wire safk_pkg::lanes_t           lanes_i,
  output safk_pkg::lanes_t                lanes_o
);

  safk_pkg::lanes_t lanes_d, lanes_q;

  always_comb begin
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    for (int l = 0; l < safk_pkg::NumJoints; l++) begin
      dx = lanes_i[l].y >>> step_i;
      dy = lanes_i[l].x >>> step_i;
      lanes_d[l].neg = lanes_i[l].neg;
      if (lanes_i[l].z >= 64'sd0) begin
        lanes_d[l].x = lanes_i[l].x - dx;
        lanes_d[l].y = lanes_i[l].y + dy;
        lanes_d[l].z = lanes_i[l].z - safk_pkg::AtanTab[step_i];
      end else begin
        lanes_d[l].x = lanes_i[l].x + dx;
        lanes_d[l].y = lanes_i[l].y - dy;
        lanes_d[l].z = lanes_i[l].z + safk_pkg::AtanTab[step_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign lanes_o = lanes_q;

endmodule
`default_nettype wire

// File: src/safk_compose.sv
`default_nettype none
module safk_compose (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire safk_pkg::pose_t pose_i,
  input  wire safk_pkg::mat_t  m_i,
  input  wire safk_pkg::vec_t  t_i,
  output safk_pkg::pose_t      pose_o
);

  logic signed [63:0] rp_q [0:2][0:2][0:2];
  logic signed [63:0] tp_q [0:2][0:2];
  safk_pkg::vec_t     p_q;
  safk_pkg::pose_t    pose_d, pose_q;

  // first stage: all partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          for (int j = 0; j < 3; j++) begin
            rp_q[i][j][k] <= 64'(pose_i.r[i*3+k]) * 64'(m_i[k*3+j]);
          end
          tp_q[i][k] <= 64'(pose_i.r[i*3+k]) * 64'(t_i[k]);
        end
      end
      p_q <= pose_i.p;
    end
  end

  // second stage: round each term, add, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pose_d.r[i*3+j] = safk_pkg::sat32(72'(safk_pkg::rnd30(rp_q[i][j][0]))
                                        + 72'(safk_pkg::rnd30(rp_q[i][j][1]))
                                        + 72'(safk_pkg::rnd30(rp_q[i][j][2])));
      end
      pose_d.p[i] = safk_pkg::sat32(72'(p_q[i])
                                  + 72'(safk_pkg::rnd30(tp_q[i][0]))
                                  + 72'(safk_pkg::rnd30(tp_q[i][1]))
                                  + 72'(safk_pkg::rnd30(tp_q[i][2])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pose_q <= pose_d;
    end
  end

  assign pose_o = pose_q;

endmodule
`default_nettype wire

// File: src/safk_seg_cell.sv
`default_nettype none
module safk_seg_cell (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [safk_pkg::SegW-1:0] seg_i,
  input  wire safk_pkg::pose_t           pose_i,
  input  wire safk_pkg::sc_vec_t         sc_i,
  output safk_pkg::pose_t                pose_o,
  output safk_pkg::sc_vec_t              sc_o
);

  safk_pkg::pose_t   pose_mid;
  safk_pkg::mat_t    rot1_q, rot2_q;
  safk_pkg::sc_vec_t sc_q [0:3];

  safk_compose u_origin (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .pose_i (pose_i),
    .m_i    (safk_pkg::SegRot[seg_i]),
    .t_i    (safk_pkg::SegPos[seg_i]),
    .pose_o (pose_mid)
  );

  // joint rotation is built while the origin transform is applied
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot1_q <= safk_pkg::rodrigues(safk_pkg::SegAxis[seg_i], sc_i[seg_i].s, sc_i[seg_i].c);
      rot2_q <= rot1_q;
      sc_q[0] <= sc_i;
      for (int n = 1; n < 4; n++) begin
        sc_q[n] <= sc_q[n-1];
      end
    end
  end

  safk_compose u_joint (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .pose_i (pose_mid),
    .m_i    (rot2_q),
    .t_i    (safk_pkg::ZeroPos),
    .pose_o (pose_o)
  );

  assign sc_o = sc_q[3];

endmodule
`default_nettype wire

// File: src/serial_arm_forward_kinematics.sv
// Channel  | Handshake                 | Payload
// -------- | ------------------------- | ------------------------------------
// input    | in_valid_i / in_ready_o   | joint_0_i .. joint_5_i (Q5.27 rad)
// output   | out_valid_o / out_ready_i | rot_00_o .. rot_22_o, pos_x/y/z_o
//
// One item per cycle while the output is not stalled. The pipeline runs
// through the angle prep, the CORDIC cell row, the sine/cosine register, the
// two matrix products in each segment cell and the tool transform product.
// Reset clears only the valid bits of the pipeline.
// A stalled output freezes the whole pipeline; the last product stage is the
// output register.
`default_nettype none
`include "serial_arm_forward_kinematics_defines.svh"
module serial_arm_forward_kinematics (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] joint_0_i,
  input  wire logic signed [31:0] joint_1_i,
  input  wire logic signed [31:0] joint_2_i,
  input  wire logic signed [31:0] joint_3_i,
  input  wire logic signed [31:0] joint_4_i,
  input  wire logic signed [31:0] joint_5_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      rot_00_o,
  output logic signed [31:0]      rot_01_o,
  output logic signed [31:0]      rot_02_o,
  output logic signed [31:0]      rot_10_o,
  output logic signed [31:0]      rot_11_o,
  output logic signed [31:0]      rot_12_o,
  output logic signed [31:0]      rot_20_o,
  output logic signed [31:0]      rot_21_o,
  output logic signed [31:0]      rot_22_o,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      pos_z_o
);

  localparam int Lat = 2 + safk_pkg::CordicSteps + 1 + 4 * safk_pkg::SegEff + 2;

  logic             en;
  logic [Lat-1:0]   vld_q, vld_d;
  safk_pkg::joints_t joints;
  safk_pkg::lanes_t  lanes_w [0:safk_pkg::CordicSteps];
  safk_pkg::sc_vec_t sc_q;
  safk_pkg::sc_vec_t sc_w   [0:safk_pkg::SegEff];
  safk_pkg::pose_t   pose_w [0:safk_pkg::SegEff];
  safk_pkg::pose_t   out_pose;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign vld_d = {vld_q[Lat-2:0], in_valid_i && in_ready_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q[Lat-1];

  assign joints = '{joint_0_i, joint_1_i, joint_2_i, joint_3_i, joint_4_i, joint_5_i};

  safk_angle_prep u_prep (
    .clk_i    (clk_i),
    .en_i     (en),
    .joints_i (joints),
    .lanes_o  (lanes_w[0])
  );

  for (genvar g = 0; g < safk_pkg::CordicSteps; g++) begin : g_cordic
    safk_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .step_i  (safk_pkg::StepW'(g)),
      .lanes_i (lanes_w[g]),
      .lanes_o (lanes_w[g+1])
    );
  end

  // back to Q2.30 and undo the fold
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < safk_pkg::NumJoints; l++) begin
        if (lanes_w[safk_pkg::CordicSteps][l].neg) begin
          sc_q[l].s <= -35'(safk_pkg::rnd30(lanes_w[safk_pkg::CordicSteps][l].y));
          sc_q[l].c <= -35'(safk_pkg::rnd30(lanes_w[safk_pkg::CordicSteps][l].x));
        end else begin
          sc_q[l].s <= 35'(safk_pkg::rnd30(lanes_w[safk_pkg::CordicSteps][l].y));
          sc_q[l].c <= 35'(safk_pkg::rnd30(lanes_w[safk_pkg::CordicSteps][l].x));
        end
      end
    end
  end

  assign pose_w[0] = safk_pkg::PoseIdent;
  assign sc_w[0]   = sc_q;

  for (genvar g = 0; g < safk_pkg::SegEff; g++) begin : g_seg
    safk_seg_cell u_seg (
      .clk_i  (clk_i),
      .en_i   (en),
      .seg_i  (safk_pkg::SegW'(g)),
      .pose_i (pose_w[g]),
      .sc_i   (sc_w[g]),
      .pose_o (pose_w[g+1]),
      .sc_o   (sc_w[g+1])
    );
  end

  safk_compose u_tool (
    .clk_i  (clk_i),
    .en_i   (en),
    .pose_i (pose_w[safk_pkg::SegEff]),
    .m_i    (safk_pkg::ToolRot),
    .t_i    (safk_pkg::ToolPos),
    .pose_o (out_pose)
  );

  assign rot_00_o = out_pose.r[0];
  assign rot_01_o = out_pose.r[1];
  assign rot_02_o = out_pose.r[2];
  assign rot_10_o = out_pose.r[3];
  assign rot_11_o = out_pose.r[4];
  assign rot_12_o = out_pose.r[5];
  assign rot_20_o = out_pose.r[6];
  assign rot_21_o = out_pose.r[7];
  assign rot_22_o = out_pose.r[8];
  assign pos_x_o  = out_pose.p[0];
  assign pos_y_o  = out_pose.p[1];
  assign pos_z_o  = out_pose.p[2];

  `SAFK_ASSERT(a_transfer_enters, in_valid_i && in_ready_o |=> vld_q[0])
  `SAFK_ASSERT(a_stall_freezes, !in_ready_o |=> $stable(vld_q))
  `SAFK_NEVER(a_ready_when_empty, !out_valid_o && !in_ready_o)

endmodule
`default_nettype wire
